### rtl/eight_bit_cpu_alu_with_flags_core_macros.svh
// Assertion macros shared by the ALU core RTL.
// Needs clk and arst_n in the scope that uses the macros.
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_MACROS_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECPU_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ECPU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/ecpu_alu_pkg.sv
// Shared types and constants for the 8-bit CPU ALU core.
// No dependencies; used by ecpu_alu and the top level.
package ecpu_alu_pkg;

	typedef enum logic [5:0] {
		OP_ADD    = 6'd0,
		OP_ADC    = 6'd1,
		OP_SUB    = 6'd2,
		OP_SBC    = 6'd3,
		OP_AND    = 6'd4,
		OP_OR     = 6'd5,
		OP_XOR    = 6'd6,
		OP_CP     = 6'd7,
		OP_INC    = 6'd8,
		OP_DEC    = 6'd9,
		OP_SWAP   = 6'd10,
		OP_DAA    = 6'd11,
		OP_CPL    = 6'd12,
		OP_CCF    = 6'd13,
		OP_SCF    = 6'd14,
		OP_RLCA   = 6'd15,
		OP_RLA    = 6'd16,
		OP_RRCA   = 6'd17,
		OP_RRA    = 6'd18,
		OP_RLC    = 6'd19,
		OP_RL     = 6'd20,
		OP_RRC    = 6'd21,
		OP_RR     = 6'd22,
		OP_SLA    = 6'd23,
		OP_SRA    = 6'd24,
		OP_SRL    = 6'd25,
		OP_BIT    = 6'd26,
		OP_SET    = 6'd27,
		OP_RES    = 6'd28,
		OP_ADD16  = 6'd29,
		OP_ADDSP  = 6'd30,
		OP_INC16  = 6'd31,
		OP_DEC16  = 6'd32
	} op_t;

	typedef struct packed {
		op_t         operation;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
		logic [2:0]  bit_index;
		logic        zero_in;
		logic        subtract_in;
		logic        half_carry_in;
		logic        carry_in;
	} item_t;

	typedef struct packed {
		logic [15:0] result;
		logic        write_result;
		logic        zero_out;
		logic        subtract_out;
		logic        half_carry_out;
		logic        carry_out;
	} res_t;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 24;

	// Decimal adjust constants.
	localparam logic [7:0] DAA_LOW_ADJ    = 8'h06;
	localparam logic [7:0] DAA_HIGH_ADJ   = 8'h60;
	localparam logic [8:0] DAA_HIGH_LIMIT = 9'h09F;
	localparam logic [3:0] BCD_DIGIT_MAX  = 4'd9;

endpackage

### rtl/ecpu_alu.sv
// Combinational datapath of the 8-bit CPU ALU: value, write enable and flags.
// Depends on ecpu_alu_pkg.
module ecpu_alu (
	input  ecpu_alu_pkg::item_t item,
	output ecpu_alu_pkg::res_t  res
);

	logic [7:0]  a;
	logic [7:0]  b;
	logic        cx_add;
	logic        cx_sub;
	logic [8:0]  sum8;
	logic [8:0]  dif8;
	logic [7:0]  hx_add;
	logic [7:0]  hx_sub;
	logic [16:0] sum16;
	logic [15:0] hx16;
	logic [8:0]  low8;
	logic [7:0]  hx_low;
	logic [15:0] sp_sum;
	logic [8:0]  daa_t;
	logic [7:0]  bmask;
	logic [7:0]  r8;

	assign a      = item.operand_a[7:0];
	assign b      = item.operand_b[7:0];
	assign cx_add = (item.operation == ecpu_alu_pkg::OP_ADC) ? item.carry_in : 1'b0;
	assign cx_sub = (item.operation == ecpu_alu_pkg::OP_SBC) ? item.carry_in : 1'b0;
	assign sum8   = {1'b0, a} + {1'b0, b} + {8'd0, cx_add};
	assign dif8   = {1'b0, a} - {1'b0, b} - {8'd0, cx_sub};
	assign hx_add = a ^ b ^ sum8[7:0];
	assign hx_sub = a ^ b ^ dif8[7:0];
	assign sum16  = {1'b0, item.operand_a} + {1'b0, item.operand_b};
	assign hx16   = item.operand_a ^ item.operand_b ^ sum16[15:0];
	assign low8   = {1'b0, item.operand_a[7:0]} + {1'b0, b};
	assign hx_low = item.operand_a[7:0] ^ b ^ low8[7:0];
	assign sp_sum = item.operand_a + {{8{b[7]}}, b};
	assign bmask  = 8'd1 << item.bit_index;

	// Decimal adjust after an add or a subtract.
	always_comb begin
		daa_t = {1'b0, a};
		if (!item.subtract_in) begin
			if (item.half_carry_in || (a[3:0] > ecpu_alu_pkg::BCD_DIGIT_MAX))
				daa_t = daa_t + {1'b0, ecpu_alu_pkg::DAA_LOW_ADJ};
			if (item.carry_in || (daa_t > ecpu_alu_pkg::DAA_HIGH_LIMIT))
				daa_t = daa_t + {1'b0, ecpu_alu_pkg::DAA_HIGH_ADJ};
		end else begin
			if (item.half_carry_in)
				daa_t = {1'b0, daa_t[7:0] - ecpu_alu_pkg::DAA_LOW_ADJ};
			if (item.carry_in)
				daa_t = {1'b0, daa_t[7:0] - ecpu_alu_pkg::DAA_HIGH_ADJ};
		end
	end

	always_comb begin
		r8                 = 8'd0;
		res.result         = 16'd0;
		res.write_result   = 1'b1;
		res.zero_out       = item.zero_in;
		res.subtract_out   = item.subtract_in;
		res.half_carry_out = item.half_carry_in;
		res.carry_out      = item.carry_in;
		case (item.operation) inside
			ecpu_alu_pkg::OP_ADD, ecpu_alu_pkg::OP_ADC: begin
				r8                 = sum8[7:0];
				res.subtract_out   = 1'b0;
				res.half_carry_out = hx_add[4];
				res.carry_out      = sum8[8];
			end
			ecpu_alu_pkg::OP_SUB, ecpu_alu_pkg::OP_SBC, ecpu_alu_pkg::OP_CP: begin
				r8                 = dif8[7:0];
				res.subtract_out   = 1'b1;
				res.half_carry_out = hx_sub[4];
				res.carry_out      = dif8[8];
			end
			ecpu_alu_pkg::OP_AND: begin
				r8                 = a & b;
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b1;
				res.carry_out      = 1'b0;
			end
			ecpu_alu_pkg::OP_OR, ecpu_alu_pkg::OP_XOR: begin
				r8                 = (item.operation == ecpu_alu_pkg::OP_OR) ? (a | b) : (a ^ b);
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
				res.carry_out      = 1'b0;
			end
			ecpu_alu_pkg::OP_INC: begin
				r8                 = a + 8'd1;
				res.subtract_out   = 1'b0;
				res.half_carry_out = (a[3:0] == 4'hF);
			end
			ecpu_alu_pkg::OP_DEC: begin
				r8                 = a - 8'd1;
				res.subtract_out   = 1'b1;
				res.half_carry_out = (a[3:0] == 4'h0);
			end
			ecpu_alu_pkg::OP_SWAP: begin
				r8                 = {a[3:0], a[7:4]};
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
				res.carry_out      = 1'b0;
			end
			ecpu_alu_pkg::OP_DAA: begin
				r8                 = daa_t[7:0];
				res.half_carry_out = 1'b0;
				res.carry_out      = item.carry_in | daa_t[8];
			end
			ecpu_alu_pkg::OP_CPL: begin
				r8                 = ~a;
				res.subtract_out   = 1'b1;
				res.half_carry_out = 1'b1;
			end
			ecpu_alu_pkg::OP_CCF, ecpu_alu_pkg::OP_SCF: begin
				res.write_result   = 1'b0;
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
				res.carry_out      = (item.operation == ecpu_alu_pkg::OP_SCF) | ~item.carry_in;
			end
			ecpu_alu_pkg::OP_RLCA, ecpu_alu_pkg::OP_RLC: begin
				r8                 = {a[6:0], a[7]};
				res.carry_out      = a[7];
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
			end
			ecpu_alu_pkg::OP_RLA, ecpu_alu_pkg::OP_RL: begin
				r8                 = {a[6:0], item.carry_in};
				res.carry_out      = a[7];
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
			end
			ecpu_alu_pkg::OP_RRCA, ecpu_alu_pkg::OP_RRC: begin
				r8                 = {a[0], a[7:1]};
				res.carry_out      = a[0];
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
			end
			ecpu_alu_pkg::OP_RRA, ecpu_alu_pkg::OP_RR: begin
				r8                 = {item.carry_in, a[7:1]};
				res.carry_out      = a[0];
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
			end
			ecpu_alu_pkg::OP_SLA: begin
				r8                 = {a[6:0], 1'b0};
				res.carry_out      = a[7];
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
			end
			ecpu_alu_pkg::OP_SRA, ecpu_alu_pkg::OP_SRL: begin
				r8                 = {(item.operation == ecpu_alu_pkg::OP_SRA) & a[7], a[7:1]};
				res.carry_out      = a[0];
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b0;
			end
			ecpu_alu_pkg::OP_BIT: begin
				res.write_result   = 1'b0;
				res.zero_out       = ~|(a & bmask);
				res.subtract_out   = 1'b0;
				res.half_carry_out = 1'b1;
			end
			ecpu_alu_pkg::OP_SET: begin
				r8 = a | bmask;
			end
			ecpu_alu_pkg::OP_RES: begin
				r8 = a & ~bmask;
			end
			ecpu_alu_pkg::OP_ADD16: begin
				res.result         = sum16[15:0];
				res.subtract_out   = 1'b0;
				res.half_carry_out = hx16[12];
				res.carry_out      = sum16[16];
			end
			ecpu_alu_pkg::OP_ADDSP: begin
				res.result         = sp_sum;
				res.zero_out       = 1'b0;
				res.subtract_out   = 1'b0;
				res.half_carry_out = hx_low[4];
				res.carry_out      = low8[8];
			end
			ecpu_alu_pkg::OP_INC16: begin
				res.result = item.operand_a + 16'd1;
			end
			ecpu_alu_pkg::OP_DEC16: begin
				res.result = item.operand_a - 16'd1;
			end
			default: begin
				res.write_result = 1'b0;
			end
		endcase

		// Byte-wide ops: place the value (not CP) and set Z (not CPL, SET, RES).
		case (item.operation) inside
			ecpu_alu_pkg::OP_ADD, ecpu_alu_pkg::OP_ADC, ecpu_alu_pkg::OP_SUB,
			ecpu_alu_pkg::OP_SBC, ecpu_alu_pkg::OP_AND, ecpu_alu_pkg::OP_OR,
			ecpu_alu_pkg::OP_XOR, ecpu_alu_pkg::OP_INC, ecpu_alu_pkg::OP_DEC,
			ecpu_alu_pkg::OP_SWAP, ecpu_alu_pkg::OP_DAA, ecpu_alu_pkg::OP_RLC,
			ecpu_alu_pkg::OP_RL, ecpu_alu_pkg::OP_RRC, ecpu_alu_pkg::OP_RR,
			ecpu_alu_pkg::OP_SLA, ecpu_alu_pkg::OP_SRA, ecpu_alu_pkg::OP_SRL: begin
				res.result   = {8'd0, r8};
				res.zero_out = (r8 == 8'd0);
			end
			ecpu_alu_pkg::OP_CP: begin
				res.write_result = 1'b0;
				res.zero_out     = (r8 == 8'd0);
			end
			ecpu_alu_pkg::OP_RLCA, ecpu_alu_pkg::OP_RLA, ecpu_alu_pkg::OP_RRCA,
			ecpu_alu_pkg::OP_RRA: begin
				res.result   = {8'd0, r8};
				res.zero_out = 1'b0;
			end
			ecpu_alu_pkg::OP_CPL, ecpu_alu_pkg::OP_SET, ecpu_alu_pkg::OP_RES: begin
				res.result = {8'd0, r8};
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/eight_bit_cpu_alu_with_flags_core.sv
// Top level of the 8-bit CPU ALU core: stream ports, input and result registers.
// Depends on ecpu_alu_pkg, ecpu_alu and eight_bit_cpu_alu_with_flags_core_macros.svh.
//
// Usage: the execute stage of a CPU sends one operation per word on the s_ side
// (operation, operands, bit index and the current Z, N, H, C flags) and takes
// one word per operation on the m_ side (value, write enable, new flags).
// Every input word gives exactly one result word, in order.
// Flow: an accepted word enters the input register; its result is loaded into the
// result register when that is empty or being drained, and m_tvalid shows it from
// then on until the receiver takes it.
// Throughput: one word per cycle while m_tready is high. The whole computation is a
// single combinational pass between the input register and the result register.
// Stalls: when the receiver holds m_tready low, the result register keeps its
// word, the input register keeps the next word behind it, and s_tready drops
// once both are full. Nothing is dropped or repeated.
// Reset: arst_n clears both valid flags at once; no words are in flight after
// reset and s_tready is high.
`include "eight_bit_cpu_alu_with_flags_core_macros.svh"

module eight_bit_cpu_alu_with_flags_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// s_tdata, low bit up: operation[5:0], operand_a[21:6], operand_b[37:22],
	// bit_index[40:38], zero_in[41], subtract_in[42], half_carry_in[43],
	// carry_in[44], zero padding[47:45].
	input  logic [ecpu_alu_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// m_tdata, low bit up: result[15:0], write_result[16], zero_out[17],
	// subtract_out[18], half_carry_out[19], carry_out[20], zero padding[23:21].
	output logic [ecpu_alu_pkg::OUT_DATA_W-1:0] m_tdata
);

	ecpu_alu_pkg::item_t in_word;
	ecpu_alu_pkg::item_t item_s1;
	ecpu_alu_pkg::res_t  alu_res;
	ecpu_alu_pkg::res_t  res_s2;
	logic                valid_s1;
	logic                valid_s2;
	logic                adv_s2;
	logic                take_in;

	// Unpack the incoming word into its fields.
	assign in_word.operation     = ecpu_alu_pkg::op_t'(s_tdata[5:0]);
	assign in_word.operand_a     = s_tdata[21:6];
	assign in_word.operand_b     = s_tdata[37:22];
	assign in_word.bit_index     = s_tdata[40:38];
	assign in_word.zero_in       = s_tdata[41];
	assign in_word.subtract_in   = s_tdata[42];
	assign in_word.half_carry_in = s_tdata[43];
	assign in_word.carry_in      = s_tdata[44];

	// The result register takes a new word whenever it is empty or being drained.
	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s2;
	assign take_in  = s_tvalid && s_tready;

	ecpu_alu u_alu (
		.item (item_s1),
		.res  (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv_s2)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (take_in)
			item_s1 <= in_word;
		if (adv_s2)
			res_s2 <= alu_res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, res_s2.carry_out, res_s2.half_carry_out,
		res_s2.subtract_out, res_s2.zero_out, res_s2.write_result, res_s2.result};

	// An accepted word always lands in the input register.
	`ECPU_ASSERT_NEXT(a_take_fills_s1, take_in, valid_s1)
	// A word moved out of the input register shows up at the output.
	`ECPU_ASSERT_NEXT(a_adv_fills_s2, adv_s2, valid_s2)
	// A word held in the input register behind a stalled output is not lost.
	`ECPU_ASSERT_NEXT(a_s1_held, valid_s1 && valid_s2 && !m_tready, valid_s1)
	// Operations that do not write never carry a value.
	`ECPU_ASSERT_SAME(a_nowrite_zero, valid_s2 && !res_s2.write_result, res_s2.result == 16'd0)

endmodule

### dv/eight_bit_cpu_alu_with_flags_core_tb.sv
// Self-checking testbench for the 8-bit CPU ALU core with flags.
// Depends on ecpu_alu_pkg and the eight_bit_cpu_alu_with_flags_core RTL;
// drives directed and random words through both stream ports.
module eight_bit_cpu_alu_with_flags_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Largest value that the 6-bit operation field can carry.
	localparam int OP_CODE_MAX = 63;
	// Random words after the directed part; the total lands near 950.
	localparam int RANDOM_WORDS = 912;
	// From this random word on, neither side idles any more.
	localparam int CALM_FROM = 780;
	// Random word at which the receiver starts its long hold-off.
	localparam int HOLD_AT = 300;
	localparam int LONG_HOLD_CYCLES = 48;
	// Cycles with no word moving on either side before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	// An expectation together with the word that caused it, for reporting.
	typedef struct {
		ecpu_alu_pkg::item_t cause;
		ecpu_alu_pkg::res_t  outcome;
	} pending_t;

	// Holds the expected result words in order and compares returned words
	// against them field by field.
	class flag_result_board;
		pending_t    awaited_results[$];
		int unsigned mismatch_count;

		function new();
			mismatch_count = 0;
		endfunction

		// Works out what the ALU must return for one word.
		function ecpu_alu_pkg::res_t compute_alu_outcome(ecpu_alu_pkg::item_t w);
			ecpu_alu_pkg::res_t r;
			logic [7:0]  a8;
			logic [7:0]  b8;
			logic [7:0]  r8;
			logic [15:0] t16;
			logic [15:0] ext;
			logic [15:0] cb16;
			logic [16:0] s17;
			logic [16:0] cb17;
			logic        cin;

			a8 = w.operand_a[7:0];
			b8 = w.operand_b[7:0];
			r8 = '0;
			t16 = '0;
			ext = '0;
			cb16 = '0;
			s17 = '0;
			cb17 = '0;
			cin = 1'b0;
			// Flags that an operation does not touch pass straight through.
			r.result = '0;
			r.write_result = 1'b1;
			r.zero_out = w.zero_in;
			r.subtract_out = w.subtract_in;
			r.half_carry_out = w.half_carry_in;
			r.carry_out = w.carry_in;

			case (w.operation)
				ecpu_alu_pkg::OP_ADD, ecpu_alu_pkg::OP_ADC: begin
					cin = (w.operation == ecpu_alu_pkg::OP_ADC) && w.carry_in;
					t16 = {8'h00, a8} + {8'h00, b8} + {15'd0, cin};
					cb16 = {8'h00, a8} ^ {8'h00, b8} ^ t16;
					r.result = {8'h00, t16[7:0]};
					r.zero_out = (t16[7:0] == 8'h00);
					r.subtract_out = 1'b0;
					r.half_carry_out = cb16[4];
					r.carry_out = cb16[8];
				end
				ecpu_alu_pkg::OP_SUB, ecpu_alu_pkg::OP_SBC, ecpu_alu_pkg::OP_CP: begin
					cin = (w.operation == ecpu_alu_pkg::OP_SBC) && w.carry_in;
					t16 = {8'h00, a8} - {8'h00, b8} - {15'd0, cin};
					cb16 = {8'h00, a8} ^ {8'h00, b8} ^ t16;
					r.result = {8'h00, t16[7:0]};
					r.zero_out = (t16[7:0] == 8'h00);
					r.subtract_out = 1'b1;
					r.half_carry_out = cb16[4];
					r.carry_out = cb16[8];
					if (w.operation == ecpu_alu_pkg::OP_CP) begin
						r.result = '0;
						r.write_result = 1'b0;
					end
				end
				ecpu_alu_pkg::OP_AND, ecpu_alu_pkg::OP_OR, ecpu_alu_pkg::OP_XOR: begin
					if (w.operation == ecpu_alu_pkg::OP_AND)
						r8 = a8 & b8;
					else if (w.operation == ecpu_alu_pkg::OP_OR)
						r8 = a8 | b8;
					else
						r8 = a8 ^ b8;
					r.result = {8'h00, r8};
					r.zero_out = (r8 == 8'h00);
					r.subtract_out = 1'b0;
					r.half_carry_out = (w.operation == ecpu_alu_pkg::OP_AND);
					r.carry_out = 1'b0;
				end
				ecpu_alu_pkg::OP_INC: begin
					r8 = a8 + 8'd1;
					r.result = {8'h00, r8};
					r.zero_out = (r8 == 8'h00);
					r.subtract_out = 1'b0;
					r.half_carry_out = (a8[3:0] == 4'hF);
				end
				ecpu_alu_pkg::OP_DEC: begin
					r8 = a8 - 8'd1;
					r.result = {8'h00, r8};
					r.zero_out = (r8 == 8'h00);
					r.subtract_out = 1'b1;
					r.half_carry_out = (a8[3:0] == 4'h0);
				end
				ecpu_alu_pkg::OP_SWAP: begin
					r8 = {a8[3:0], a8[7:4]};
					r.result = {8'h00, r8};
					r.zero_out = (r8 == 8'h00);
					r.subtract_out = 1'b0;
					r.half_carry_out = 1'b0;
					r.carry_out = 1'b0;
				end
				ecpu_alu_pkg::OP_DAA: begin
					t16 = {8'h00, a8};
					if (!w.subtract_in) begin
						if (w.half_carry_in || t16[3:0] > ecpu_alu_pkg::BCD_DIGIT_MAX)
							t16 = t16 + {8'h00, ecpu_alu_pkg::DAA_LOW_ADJ};
						if (w.carry_in || t16 > {7'h00, ecpu_alu_pkg::DAA_HIGH_LIMIT})
							t16 = t16 + {8'h00, ecpu_alu_pkg::DAA_HIGH_ADJ};
					end else begin
						if (w.half_carry_in)
							t16 = {8'h00, t16[7:0] - ecpu_alu_pkg::DAA_LOW_ADJ};
						if (w.carry_in)
							t16 = t16 - {8'h00, ecpu_alu_pkg::DAA_HIGH_ADJ};
					end
					r.carry_out = w.carry_in | t16[8];
					r.result = {8'h00, t16[7:0]};
					r.zero_out = (t16[7:0] == 8'h00);
					r.half_carry_out = 1'b0;
				end
				ecpu_alu_pkg::OP_CPL: begin
					r.result = {8'h00, ~a8};
					r.subtract_out = 1'b1;
					r.half_carry_out = 1'b1;
				end
				ecpu_alu_pkg::OP_CCF, ecpu_alu_pkg::OP_SCF: begin
					r.write_result = 1'b0;
					r.subtract_out = 1'b0;
					r.half_carry_out = 1'b0;
					r.carry_out = (w.operation == ecpu_alu_pkg::OP_SCF) ? 1'b1 : ~w.carry_in;
				end
				ecpu_alu_pkg::OP_RLCA, ecpu_alu_pkg::OP_RLA, ecpu_alu_pkg::OP_RRCA,
				ecpu_alu_pkg::OP_RRA, ecpu_alu_pkg::OP_RLC, ecpu_alu_pkg::OP_RL,
				ecpu_alu_pkg::OP_RRC, ecpu_alu_pkg::OP_RR, ecpu_alu_pkg::OP_SLA,
				ecpu_alu_pkg::OP_SRA, ecpu_alu_pkg::OP_SRL: begin
					case (w.operation)
						ecpu_alu_pkg::OP_RLCA, ecpu_alu_pkg::OP_RLC:
							r8 = {a8[6:0], a8[7]};
						ecpu_alu_pkg::OP_RLA, ecpu_alu_pkg::OP_RL:
							r8 = {a8[6:0], w.carry_in};
						ecpu_alu_pkg::OP_RRCA, ecpu_alu_pkg::OP_RRC:
							r8 = {a8[0], a8[7:1]};
						ecpu_alu_pkg::OP_RRA, ecpu_alu_pkg::OP_RR:
							r8 = {w.carry_in, a8[7:1]};
						ecpu_alu_pkg::OP_SLA:
							r8 = {a8[6:0], 1'b0};
						ecpu_alu_pkg::OP_SRA:
							r8 = {a8[7], a8[7:1]};
						default:
							r8 = {1'b0, a8[7:1]};
					endcase
					r.result = {8'h00, r8};
					// Left moves push bit 7 out, right moves push bit 0 out.
					if (w.operation inside {ecpu_alu_pkg::OP_RLCA, ecpu_alu_pkg::OP_RLA,
							ecpu_alu_pkg::OP_RLC, ecpu_alu_pkg::OP_RL, ecpu_alu_pkg::OP_SLA})
						r.carry_out = a8[7];
					else
						r.carry_out = a8[0];
					// The accumulator forms always clear Z.
					if (w.operation inside {ecpu_alu_pkg::OP_RLCA, ecpu_alu_pkg::OP_RLA,
							ecpu_alu_pkg::OP_RRCA, ecpu_alu_pkg::OP_RRA})
						r.zero_out = 1'b0;
					else
						r.zero_out = (r8 == 8'h00);
					r.subtract_out = 1'b0;
					r.half_carry_out = 1'b0;
				end
				ecpu_alu_pkg::OP_BIT: begin
					r.write_result = 1'b0;
					r.zero_out = ~a8[w.bit_index];
					r.subtract_out = 1'b0;
					r.half_carry_out = 1'b1;
				end
				ecpu_alu_pkg::OP_SET: r.result = {8'h00, a8 | (8'h01 << w.bit_index)};
				ecpu_alu_pkg::OP_RES: r.result = {8'h00, a8 & ~(8'h01 << w.bit_index)};
				ecpu_alu_pkg::OP_ADD16: begin
					s17 = {1'b0, w.operand_a} + {1'b0, w.operand_b};
					cb17 = {1'b0, w.operand_a} ^ {1'b0, w.operand_b} ^ s17;
					r.result = s17[15:0];
					r.subtract_out = 1'b0;
					r.half_carry_out = cb17[12];
					r.carry_out = cb17[16];
				end
				ecpu_alu_pkg::OP_ADDSP: begin
					ext = {{8{b8[7]}}, b8};
					t16 = w.operand_a + ext;
					cb16 = w.operand_a ^ ext ^ t16;
					r.result = t16;
					r.zero_out = 1'b0;
					r.subtract_out = 1'b0;
					r.half_carry_out = cb16[4];
					r.carry_out = cb16[8];
				end
				ecpu_alu_pkg::OP_INC16: r.result = w.operand_a + 16'd1;
				ecpu_alu_pkg::OP_DEC16: r.result = w.operand_a - 16'd1;
				default: begin
					r.result = '0;
					r.write_result = 1'b0;
				end
			endcase
			return r;
		endfunction

		function void note_issued(ecpu_alu_pkg::item_t w);
			pending_t p;
			p.cause = w;
			p.outcome = compute_alu_outcome(w);
			awaited_results.push_back(p);
		endfunction

		function void check_returned(ecpu_alu_pkg::res_t got);
			pending_t p;
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("ERROR: result word %h arrived with nothing outstanding", got);
				return;
			end
			p = awaited_results.pop_front();
			if (got.result != p.outcome.result ||
					got.write_result != p.outcome.write_result ||
					got.zero_out != p.outcome.zero_out ||
					got.subtract_out != p.outcome.subtract_out ||
					got.half_carry_out != p.outcome.half_carry_out ||
					got.carry_out != p.outcome.carry_out) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("ERROR: op %0d a %h b %h bit %0d znhc %b%b%b%b",
						p.cause.operation, p.cause.operand_a, p.cause.operand_b,
						p.cause.bit_index, p.cause.zero_in, p.cause.subtract_in,
						p.cause.half_carry_in, p.cause.carry_in);
					$display("  expected result %h wr %b znhc %b%b%b%b",
						p.outcome.result, p.outcome.write_result, p.outcome.zero_out,
						p.outcome.subtract_out, p.outcome.half_carry_out,
						p.outcome.carry_out);
					$display("  actual   result %h wr %b znhc %b%b%b%b",
						got.result, got.write_result, got.zero_out, got.subtract_out,
						got.half_carry_out, got.carry_out);
				end
			end
		endfunction

		function int unsigned pending_count();
			return awaited_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	flag_result_board board;
	// Set in the last part of the run; both sides then run without idling.
	bit          calm_phase = 1'b0;
	// Raised by the stimulus to ask the receiver for its long hold-off.
	bit          hold_off_due = 1'b0;
	int unsigned quiet_cycles = 0;

	eight_bit_cpu_alu_with_flags_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The input word layout, low bit up: operation, operand_a, operand_b,
	// bit_index, Z, N, H, C, then three bits of zero padding.
	function automatic logic [47:0] pack_word(ecpu_alu_pkg::item_t w);
		return {3'b000, w.carry_in, w.half_carry_in, w.subtract_in, w.zero_in,
			w.bit_index, w.operand_b, w.operand_a, 6'(w.operation)};
	endfunction

	function automatic ecpu_alu_pkg::item_t unpack_word(logic [47:0] d);
		ecpu_alu_pkg::item_t w;
		w.operation = ecpu_alu_pkg::op_t'(d[5:0]);
		w.operand_a = d[21:6];
		w.operand_b = d[37:22];
		w.bit_index = d[40:38];
		w.zero_in = d[41];
		w.subtract_in = d[42];
		w.half_carry_in = d[43];
		w.carry_in = d[44];
		return w;
	endfunction

	// The result word layout, low bit up: result, write enable, Z, N, H, C.
	function automatic ecpu_alu_pkg::res_t unpack_result(logic [23:0] d);
		ecpu_alu_pkg::res_t r;
		r.result = d[15:0];
		r.write_result = d[16];
		r.zero_out = d[17];
		r.subtract_out = d[18];
		r.half_carry_out = d[19];
		r.carry_out = d[20];
		return r;
	endfunction

	// Operands lean toward the values where carries and borrows turn over,
	// with fully random values the rest of the time.
	function automatic logic [15:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return {8'($urandom_range(0, 255)), 8'hFF};
			3: return {8'($urandom_range(0, 255)), 8'h80};
			4: return {8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), 4'hF};
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Most words carry a defined operation; about one in twelve carries one of
	// the unused codes, which must come back as a no-op.
	function automatic ecpu_alu_pkg::item_t random_word();
		ecpu_alu_pkg::item_t w;
		if ($urandom_range(0, 11) == 0)
			w.operation = ecpu_alu_pkg::op_t'(6'($urandom_range(
				int'(ecpu_alu_pkg::OP_DEC16) + 1, OP_CODE_MAX)));
		else
			w.operation = ecpu_alu_pkg::op_t'(6'($urandom_range(
				int'(ecpu_alu_pkg::OP_ADD), int'(ecpu_alu_pkg::OP_DEC16))));
		w.operand_a = pick_operand();
		w.operand_b = pick_operand();
		w.bit_index = 3'($urandom_range(0, 7));
		{w.zero_in, w.subtract_in, w.half_carry_in, w.carry_in} = 4'($urandom_range(0, 15));
		return w;
	endfunction

	// Offers one word and returns at the edge where it is accepted. A word that
	// follows without a gap raises nothing again, so s_tvalid simply stays high.
	task automatic send_word(input ecpu_alu_pkg::item_t w);
		s_tdata <= pack_word(w);
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Random sender gap, never in the calm phase.
	task automatic sender_gap();
		if (!calm_phase && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic issue(input ecpu_alu_pkg::op_t op, input logic [15:0] a,
			input logic [15:0] b, input logic [2:0] bi, input logic [3:0] znhc);
		ecpu_alu_pkg::item_t w;
		w.operation = op;
		w.operand_a = a;
		w.operand_b = b;
		w.bit_index = bi;
		{w.zero_in, w.subtract_in, w.half_carry_in, w.carry_in} = znhc;
		send_word(w);
		sender_gap();
	endtask

	// Both handshakes are sampled at the rising edge, before the drivers'
	// nonblocking updates land, so the monitor always sees settled values.
	// The input side is noted first; a result can never come back in the
	// same cycle that its word is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_issued(unpack_word(s_tdata));
			if (m_tvalid && m_tready)
				board.check_returned(unpack_result(m_tdata));
		end
	end

	// Watchdog: the run is hung if no word moves on either side for too long.
	// The longest legal quiet stretch is the receiver hold-off plus the time a word
	// takes through the core, far below the limit.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Receiver: short random stalls, one long hold-off on request, and no
	// stalls at all once the calm phase begins.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_due) begin
				// The sender keeps offering words meanwhile, so both internal
				// registers fill and s_tready has to drop.
				hold_off_due = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	end

	// Stimulus and end of run.
	initial begin
		ecpu_alu_pkg::item_t w;
		int unsigned         k;

		board = new();
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: every operation at least once with operands at the points
		// where results wrap, carries and borrows appear, and Z gets set.
		// The high byte of operand_a is set on several 8-bit operations to
		// show that it is ignored.
		issue(ecpu_alu_pkg::OP_ADD,   16'hFFFF, 16'h0001, 3'd0, 4'b0100);
		issue(ecpu_alu_pkg::OP_ADC,   16'h000F, 16'h0000, 3'd0, 4'b0001);
		issue(ecpu_alu_pkg::OP_SUB,   16'h0000, 16'h0001, 3'd0, 4'b1000);
		issue(ecpu_alu_pkg::OP_SBC,   16'hAB10, 16'h000F, 3'd0, 4'b0001);
		issue(ecpu_alu_pkg::OP_AND,   16'h00FF, 16'h0000, 3'd0, 4'b0000);
		issue(ecpu_alu_pkg::OP_OR,    16'hFF00, 16'hFF00, 3'd0, 4'b0111);
		issue(ecpu_alu_pkg::OP_XOR,   16'h00AA, 16'h0055, 3'd0, 4'b1111);
		// Compare of equal values sets Z but writes nothing.
		issue(ecpu_alu_pkg::OP_CP,    16'h0042, 16'h0042, 3'd0, 4'b0000);
		issue(ecpu_alu_pkg::OP_INC,   16'h12FF, 16'h0000, 3'd0, 4'b0101);
		issue(ecpu_alu_pkg::OP_DEC,   16'h0001, 16'h0000, 3'd0, 4'b0000);
		issue(ecpu_alu_pkg::OP_SWAP,  16'h00F0, 16'h0000, 3'd0, 4'b0111);
		// Decimal adjust after an add that overflows both digits, then after
		// a subtraction with both half carry and carry set.
		issue(ecpu_alu_pkg::OP_DAA,   16'h009A, 16'h0000, 3'd0, 4'b0000);
		issue(ecpu_alu_pkg::OP_DAA,   16'h0000, 16'h0000, 3'd0, 4'b0111);
		issue(ecpu_alu_pkg::OP_CPL,   16'h0000, 16'h0000, 3'd0, 4'b0000);
		issue(ecpu_alu_pkg::OP_CCF,   16'h0000, 16'h0000, 3'd0, 4'b1111);
		issue(ecpu_alu_pkg::OP_SCF,   16'h0000, 16'h0000, 3'd0, 4'b0110);
		// Accumulator rotates clear Z even when Z comes in set.
		issue(ecpu_alu_pkg::OP_RLCA,  16'h0080, 16'h0000, 3'd0, 4'b1000);
		issue(ecpu_alu_pkg::OP_RLA,   16'h0000, 16'h0000, 3'd0, 4'b1001);
		issue(ecpu_alu_pkg::OP_RRCA,  16'h0001, 16'h0000, 3'd0, 4'b1000);
		issue(ecpu_alu_pkg::OP_RRA,   16'h0000, 16'h0000, 3'd0, 4'b1001);
		issue(ecpu_alu_pkg::OP_RLC,   16'hFF00, 16'h0000, 3'd0, 4'b0111);
		issue(ecpu_alu_pkg::OP_RL,    16'h0080, 16'h0000, 3'd0, 4'b0000);
		issue(ecpu_alu_pkg::OP_RRC,   16'h0001, 16'h0000, 3'd0, 4'b0000);
		issue(ecpu_alu_pkg::OP_RR,    16'h0001, 16'h0000, 3'd0, 4'b0000);
		issue(ecpu_alu_pkg::OP_SLA,   16'h0080, 16'h0000, 3'd0, 4'b0000);
		issue(ecpu_alu_pkg::OP_SRA,   16'h0081, 16'h0000, 3'd0, 4'b0000);
		issue(ecpu_alu_pkg::OP_SRL,   16'h0001, 16'h0000, 3'd0, 4'b0000);
		issue(ecpu_alu_pkg::OP_BIT,   16'h007F, 16'h0000, 3'd7, 4'b0011);
		issue(ecpu_alu_pkg::OP_SET,   16'h0000, 16'h0000, 3'd7, 4'b1111);
		issue(ecpu_alu_pkg::OP_RES,   16'hFFFF, 16'h0000, 3'd0, 4'b0000);
		issue(ecpu_alu_pkg::OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'b1100);
		issue(ecpu_alu_pkg::OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'b0000);
		// Stack pointer plus a negative offset, and plus a positive one.
		issue(ecpu_alu_pkg::OP_ADDSP, 16'h0000, 16'hFFFF, 3'd0, 4'b1100);
		issue(ecpu_alu_pkg::OP_ADDSP, 16'hFFFF, 16'h0001, 3'd0, 4'b1100);
		issue(ecpu_alu_pkg::OP_INC16, 16'hFFFF, 16'h0000, 3'd0, 4'b1010);
		issue(ecpu_alu_pkg::OP_DEC16, 16'h0000, 16'hFFFF, 3'd0, 4'b0101);
		// The first and the last unused operation codes.
		issue(ecpu_alu_pkg::op_t'(6'(int'(ecpu_alu_pkg::OP_DEC16) + 1)),
			16'hFFFF, 16'hFFFF, 3'd7, 4'b1010);
		issue(ecpu_alu_pkg::op_t'(6'(OP_CODE_MAX)),
			16'hFFFF, 16'hFFFF, 3'd7, 4'b0101);

		// Random words. Most words are legal ALU requests; about one in twelve
		// carries an unused code, which must come back as a no-op.
		for (k = 0; k < RANDOM_WORDS; k++) begin
			if (k == HOLD_AT)
				hold_off_due = 1'b1;
			if (k == CALM_FROM)
				calm_phase = 1'b1;
			w = random_word();
			send_word(w);
			sender_gap();
		end
		s_tvalid <= 1'b0;

		// Drain: wait for every outstanding result, then idle on so
		// that a stray extra word would still be caught by the monitor.
		while (board.pending_count() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (board.mismatch_count == 0 && board.pending_count() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
